>>> rtl/smlp_pkg.sv
// Shared types, constants and the piecewise sigmoid of the sigmoid network evaluator.
package smlp_pkg;

  // Store geometry.
  localparam int MAX_INPUTS   = 16;
  localparam int MAX_NODES    = 64;
  localparam int STRIDE_MAX   = MAX_INPUTS + 2;
  localparam int WSTORE_DEPTH = MAX_NODES * STRIDE_MAX;

  // Field and register widths.
  localparam int INDEX_W    = 11;
  localparam int VALUE_W    = 32;
  localparam int OUT_W      = 40;
  localparam int CNT_W      = 7;
  localparam int INCNT_W    = 5;
  localparam int NODECNT_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Internal widths.
  localparam int WADDR_W = $clog2(WSTORE_DEPTH);
  localparam int XIDX_W  = $clog2(MAX_INPUTS);
  localparam int K_W     = $clog2(STRIDE_MAX + 1);
  localparam int NODE_W  = $clog2(MAX_NODES + 1);
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int FRAC_W  = 16;
  // One shifted product is 48 bits; the dot product adds up to MAX_INPUTS of them plus a bias.
  localparam int ARG_W   = PROD_W - FRAC_W + $clog2(MAX_INPUTS + 1);
  localparam int Y_W     = FRAC_W + 1;
  localparam int TOT_W   = OUT_W + 1;

  // Sigmoid argument magnitude counted as saturated (10.0 in Q16.16).
  localparam int ARG_LIMIT = 655360;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b1;

  // Input word modes.
  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_COORD  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_OMUL,
    S_OACC,
    S_DONE
  } smlp_state_t;

  // Role of a weight word within its node record.
  typedef enum logic [1:0] {
    KIND_OUT,
    KIND_IN,
    KIND_BIAS
  } smlp_kind_t;

  // Piecewise-linear sigmoid, result in units of 2^-16 (0..65536).
  function automatic logic [Y_W-1:0] plan_sigmoid(input logic signed [ARG_W-1:0] a);
    logic [ARG_W-1:0] m;
    logic [Y_W-1:0]   y;
    m = a[ARG_W-1] ? ARG_W'(-a) : ARG_W'(a);
    priority if (m >= ARG_W'(327680)) begin
      y = Y_W'(65536);
    end else if (m >= ARG_W'(155648)) begin
      y = Y_W'(m >> 5) + Y_W'(55296);
    end else if (m >= ARG_W'(65536)) begin
      y = Y_W'(m >> 3) + Y_W'(40960);
    end else begin
      y = Y_W'(m >> 2) + Y_W'(32768);
    end
    if (a[ARG_W-1]) begin
      y = Y_W'(65536) - y;
    end
    return y;
  endfunction

endpackage

>>> rtl/smlp_if.sv
// Valid/ready channel interfaces for input words and result words.
interface smlp_in_if import smlp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, mode, index, value, last, input ready);
  modport sink   (input valid, mode, index, value, last, output ready);
endinterface

interface smlp_out_if import smlp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] network_out;
  logic [CNT_W-1:0]        active_nodes;
  logic [CNT_W-1:0]        saturated_nodes;

  modport source (output valid, network_out, active_nodes, saturated_nodes, input ready);
  modport sink   (input valid, network_out, active_nodes, saturated_nodes, output ready);
endinterface

>>> rtl/sigmoid_mlp_forward_eval.sv
// One-hidden-layer sigmoid network evaluator: stores, sequencer and shared multiplier.
//
// Each input word writes one weight (mode 0, into a 1152-word weight memory laid out per node as
// out weight, input_count input weights, bias) or one coordinate (mode 1). Writes beyond the
// stores are dropped. A word with last set also starts an evaluation: the block walks the nodes
// with one shared 32x32 multiplier, first forming each node's Q16.16 argument as
// bias + sum of floor(x*w/2^16), then taking the piecewise sigmoid and adding
// floor(w_out*y/2^16) into a saturated Q24.16 total, and returns one result word with the total,
// the count of nodes with nonzero out weight and how many of those have |argument| >= 10.0.
// Timing: a word without last leaves the input side ready. A last word keeps the input side busy
// while it walks node_count nodes of input_count inputs each, both counts clamped to the store
// limits (no walk when node_count is 0), and while the previous result word still waits for
// the sink; each node needs one weight memory read per record word, a drain of the
// read/multiply/accumulate pipe to form the sigmoid, and the out-weight multiply and accumulate,
// all through the single multiplier and the single read port of the
// weight memory. Input words are taken again while a result word still waits for the sink.
module sigmoid_mlp_forward_eval import smlp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  smlp_in_if.sink               in_ch,
  smlp_out_if.source            out_ch
);

  // Sequencer state.
  smlp_state_t state_r, state_nxt;

  // Configuration registers.
  logic [INCNT_W-1:0]   input_count_r;
  logic [NODECNT_W-1:0] node_count_r;

  // Per-evaluation bounds and walk counters.
  logic [K_W-1:0]     n_in_r;
  logic [NODE_W-1:0]  n_nodes_r;
  logic [NODE_W-1:0]  node_r;
  logic [K_W-1:0]     k_r;
  logic [WADDR_W-1:0] base_r;

  // Stores.
  logic [VALUE_W-1:0]        wmem [WSTORE_DEPTH];
  logic signed [VALUE_W-1:0] coord_r [MAX_INPUTS];

  // Read/multiply/accumulate pipe.
  logic signed [VALUE_W-1:0] q_r;
  logic signed [VALUE_W-1:0] x1_r;
  logic                      v1_r, v2_r;
  smlp_kind_t                kind1_r;
  logic signed [PROD_W-1:0]  term2_r;

  // Per-node and per-evaluation results.
  logic signed [VALUE_W-1:0] wout_r;
  logic signed [ARG_W-1:0]   arg_r;
  logic [Y_W-1:0]            y_r;
  logic signed [TOT_W-1:0]   total_r;
  logic [CNT_W-1:0]          active_r, sat_r;

  // Output register.
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_net_r;
  logic [CNT_W-1:0]        out_active_r, out_sat_r;

  // Combinational control.
  logic                      in_ready;
  logic                      in_accept, eval_start;
  logic                      last_word, pipe_empty, out_load;
  smlp_kind_t                issue_kind;
  logic [K_W-1:0]            stride;
  logic [WADDR_W-1:0]        raddr;
  logic [XIDX_W-1:0]         xidx;
  logic [K_W-1:0]            n_in_eff;
  logic [NODE_W-1:0]         n_nodes_eff;
  logic signed [VALUE_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  product;
  logic signed [PROD_W-1:0]  shifted;
  logic                      arg_big;
  logic signed [OUT_W-1:0]   total_sat;

  assign in_accept  = in_ch.valid && in_ready;
  assign eval_start = in_accept && in_ch.last;

  // Clamp registers that exceed the store geometry.
  assign n_in_eff    = (K_W'(input_count_r) > K_W'(MAX_INPUTS)) ? K_W'(MAX_INPUTS)
                                                                : K_W'(input_count_r);
  assign n_nodes_eff = (NODE_W'(node_count_r) > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES)
                                                                    : NODE_W'(node_count_r);

  // Walk one node record: out weight, input weights, bias.
  assign stride    = n_in_r + K_W'(2);
  assign last_word = (k_r == n_in_r + K_W'(1));
  assign raddr     = base_r + WADDR_W'(k_r);
  assign xidx      = XIDX_W'(k_r - K_W'(1));
  assign pipe_empty = !v1_r && !v2_r;

  always_comb begin
    if (k_r == '0) begin
      issue_kind = KIND_OUT;
    end else if (last_word) begin
      issue_kind = KIND_BIAS;
    end else begin
      issue_kind = KIND_IN;
    end
  end

  // Shared multiplier: dot-product terms while issuing, out weight times sigmoid otherwise.
  assign mul_a   = (state_r == S_OMUL) ? wout_r : q_r;
  assign mul_b   = (state_r == S_OMUL) ? signed'(VALUE_W'(y_r)) : x1_r;
  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign shifted = term2_r >>> FRAC_W;

  assign arg_big = (arg_r >= ARG_W'(ARG_LIMIT)) || (arg_r <= -ARG_W'(ARG_LIMIT));

  // Saturate the total to the 40-bit output range.
  assign total_sat = (total_r[TOT_W-1] != total_r[TOT_W-2])
                   ? {total_r[TOT_W-1], {(OUT_W-1){~total_r[TOT_W-1]}}}
                   : total_r[OUT_W-1:0];

  // Next state and strobes.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (eval_start) begin
          state_nxt = (n_nodes_eff == '0) ? S_DONE : S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (last_word) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (pipe_empty) begin
          state_nxt = S_OMUL;
        end
      end
      S_OMUL: begin
        state_nxt = S_OACC;
      end
      S_OACC: begin
        state_nxt = (node_r + NODE_W'(1) == n_nodes_r) ? S_DONE : S_ISSUE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r <= INCNT_W'(16);
      node_count_r  <= NODECNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_COUNT: input_count_r <= cfg_data[INCNT_W-1:0];
        CFG_NODE_COUNT:  node_count_r  <= cfg_data[NODECNT_W-1:0];
      endcase
    end
  end

  // Weight memory: write from the input channel, registered read for the walk.
  always_ff @(posedge clk) begin
    if (in_accept && (in_ch.mode == MODE_WEIGHT) &&
        (in_ch.index < INDEX_W'(WSTORE_DEPTH))) begin
      wmem[in_ch.index[WADDR_W-1:0]] <= in_ch.value;
    end
    q_r <= wmem[raddr];
  end

  // Coordinate store and the coordinate that travels with each read.
  always_ff @(posedge clk) begin
    if (in_accept && (in_ch.mode == MODE_COORD) && (in_ch.index < INDEX_W'(MAX_INPUTS))) begin
      coord_r[in_ch.index[XIDX_W-1:0]] <= in_ch.value;
    end
    x1_r <= coord_r[xidx];
  end

  // Pipe valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= (state_r == S_ISSUE);
      v2_r <= v1_r && (kind1_r != KIND_OUT);
    end
  end

  // Walk counters and datapath.
  always_ff @(posedge clk) begin
    kind1_r <= issue_kind;

    if (eval_start) begin
      n_in_r    <= n_in_eff;
      n_nodes_r <= n_nodes_eff;
      node_r    <= '0;
      k_r       <= '0;
      base_r    <= '0;
      total_r   <= '0;
      active_r  <= '0;
      sat_r     <= '0;
    end

    if (state_r == S_ISSUE) begin
      if (last_word) begin
        k_r    <= '0;
        base_r <= base_r + WADDR_W'(stride);
      end else begin
        k_r <= k_r + K_W'(1);
      end
    end

    // Stage B: hold the out weight, form product or aligned bias.
    if (v1_r) begin
      unique case (kind1_r)
        KIND_OUT: begin
          wout_r <= q_r;
          arg_r  <= '0;
        end
        KIND_IN:   term2_r <= product;
        KIND_BIAS: term2_r <= {{(PROD_W-VALUE_W-FRAC_W){q_r[VALUE_W-1]}}, q_r, {FRAC_W{1'b0}}};
        default:   term2_r <= product;
      endcase
    end else if (state_r == S_OMUL) begin
      term2_r <= product;
    end

    // Stage C: accumulate the node argument.
    if (v2_r) begin
      arg_r <= arg_r + shifted[ARG_W-1:0];
    end

    // Pipe drained: take the sigmoid and count the node.
    if ((state_r == S_WAIT) && pipe_empty) begin
      y_r <= plan_sigmoid(arg_r);
      if (wout_r != '0) begin
        active_r <= active_r + CNT_W'(1);
        if (arg_big) begin
          sat_r <= sat_r + CNT_W'(1);
        end
      end
    end

    if (state_r == S_OACC) begin
      total_r <= total_r + shifted[TOT_W-1:0];
      node_r  <= node_r + NODE_W'(1);
    end

    if (out_load) begin
      out_net_r    <= total_sat;
      out_active_r <= active_r;
      out_sat_r    <= sat_r;
    end
  end

  // Result word valid: set on load, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.network_out     = out_net_r;
  assign out_ch.active_nodes    = out_active_r;
  assign out_ch.saturated_nodes = out_sat_r;

endmodule

>>> bench/sigmoid_mlp_forward_eval_tb.sv
// Self-checking bench for the sigmoid network evaluator: stores, register phases, stalls.
module sigmoid_mlp_forward_eval_tb;
  import smlp_pkg::*;

  localparam int IDX_TOP      = (1 << INDEX_W) - 1;
  // Longest evaluation the block can run, plus a small margin.
  localparam int DRAIN_CYCLES = MAX_NODES * (MAX_INPUTS + 7) + 1 + 8;
  localparam int HOLD_CYCLES  = 2500;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam int NUM_PHASES     = 11;
  localparam int PRESSURE_PHASE = 7;

  typedef struct {
    logic                mode;
    logic [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } in_word_t;

  typedef struct {
    logic signed [OUT_W-1:0] net;
    logic [CNT_W-1:0]        active;
    logic [CNT_W-1:0]        sat;
  } eval_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  smlp_in_if  in_ch ();
  smlp_out_if out_ch ();

  sigmoid_mlp_forward_eval dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register settings per phase: input_count, node_count, evaluations to run.
  // Values above the store limits and zero are part of the list on purpose.
  int ph_inputs [NUM_PHASES] = '{3, 0, 16, 31, 1, 0, 7, 2, 16, 5, 1};
  int ph_nodes  [NUM_PHASES] = '{4, 64, 1, 2, 127, 0, 0, 3, 8, 10, 1};
  int ph_evals  [NUM_PHASES] = '{40, 15, 40, 25, 10, 15, 8, 50, 15, 30, 25};

  // Words waiting for the driver, and results owed by the block.
  in_word_t     words_to_send [$];
  eval_result_t evals_due [$];

  // Mirror of the block's stores and registers, updated on accepted words.
  logic signed [VALUE_W-1:0] wt_mirror  [WSTORE_DEPTH];
  logic signed [VALUE_W-1:0] crd_mirror [MAX_INPUTS];
  logic [INCNT_W-1:0]        input_count_q;
  logic [NODECNT_W-1:0]      node_count_q;

  // Entries the stimulus has written so far; never evaluate over a hole.
  bit wt_loaded  [WSTORE_DEPTH];
  bit crd_loaded [MAX_INPUTS];

  bit word_on_bus;
  int send_gap, send_calm;
  int take_gap, take_calm;
  int hold_asks, hold_seen, hold_left;
  int mismatch_count;
  int cycle_count;

  // Pick an idle length: mostly none, some short, a few long; calm stretches have none.
  function automatic int idle_len(inout int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 3) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Q16.16 value with most weight on the range where the sigmoid bends.
  function automatic logic [VALUE_W-1:0] rand_q16();
    int unsigned pick;
    logic [VALUE_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 12) v = '0;
    else if (pick < 50) v = VALUE_W'($urandom_range(32'h18000));
    else if (pick < 75) v = VALUE_W'($urandom_range(32'hC0000));
    else if (pick < 92) v = $urandom();
    else begin
      case ($urandom_range(4))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = 32'hFFFF_FFFF;
        3: v = 32'h0001_0000;
        default: v = 32'h0000_0001;
      endcase
    end
    if (pick >= 12 && pick < 75 && $urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  // Piecewise sigmoid in units of 2^-16.
  function automatic longint squash_q16(longint a);
    longint m, y;
    m = (a < 0) ? -a : a;
    if (m >= 327680) y = 65536;
    else if (m >= 155648) y = (m >> 5) + 55296;
    else if (m >= 65536) y = (m >> 3) + 40960;
    else y = (m >> 2) + 32768;
    return (a < 0) ? 65536 - y : y;
  endfunction

  // Evaluate the network over the mirrored stores and registers.
  function automatic eval_result_t eval_network();
    eval_result_t r;
    longint       arg, w_out, x, w, total;
    longint       out_hi, out_lo;
    int           ni, nn, base, n, j;
    ni = (input_count_q > MAX_INPUTS) ? MAX_INPUTS : int'(input_count_q);
    nn = (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
    out_hi = (64'sd1 <<< (OUT_W - 1)) - 1;
    out_lo = -(64'sd1 <<< (OUT_W - 1));
    total = 0;
    r.active = '0;
    r.sat = '0;
    for (n = 0; n < nn; n++) begin
      base = n * (ni + 2);
      w_out = wt_mirror[base];
      arg = wt_mirror[base + ni + 1];
      for (j = 0; j < ni; j++) begin
        x = crd_mirror[j];
        w = wt_mirror[base + 1 + j];
        arg += (x * w) >>> 16;
      end
      total += (w_out * squash_q16(arg)) >>> 16;
      if (w_out != 0) begin
        r.active++;
        if (arg >= ARG_LIMIT || arg <= -ARG_LIMIT) r.sat++;
      end
    end
    if (total > out_hi) total = out_hi;
    if (total < out_lo) total = out_lo;
    r.net = total[OUT_W-1:0];
    return r;
  endfunction

  task automatic queue_word(logic mode, int idx, logic [VALUE_W-1:0] val, logic last);
    in_word_t w;
    w.mode = mode;
    w.index = INDEX_W'(idx);
    w.value = val;
    w.last = last;
    words_to_send.push_back(w);
    if (mode == MODE_WEIGHT && idx < WSTORE_DEPTH) wt_loaded[idx] = 1'b1;
    else if (mode == MODE_COORD && idx < MAX_INPUTS) crd_loaded[idx] = 1'b1;
  endtask

  // Fill every weight and coordinate the current layout reads that is still unwritten.
  task automatic load_used(int ni, int nn);
    int a;
    for (a = 0; a < nn * (ni + 2); a++) begin
      if (!wt_loaded[a]) queue_word(MODE_WEIGHT, a, rand_q16(), 1'b0);
    end
    for (a = 0; a < ni; a++) begin
      if (!crd_loaded[a]) queue_word(MODE_COORD, a, rand_q16(), 1'b0);
    end
  endtask

  // A few random writes, some of them out of range, then a last word.
  task automatic random_eval(int ni, int nn);
    int used, k, pick;
    used = nn * (ni + 2);
    k = $urandom_range(4);
    repeat (k) begin
      pick = $urandom_range(99);
      if (pick < 55 && used > 0)
        queue_word(MODE_WEIGHT, $urandom_range(used - 1), rand_q16(), 1'b0);
      else if (pick < 75 && ni > 0)
        queue_word(MODE_COORD, $urandom_range(ni - 1), rand_q16(), 1'b0);
      else if (pick < 83)
        queue_word(MODE_WEIGHT, $urandom_range(WSTORE_DEPTH - 1), rand_q16(), 1'b0);
      else if (pick < 91)
        queue_word(MODE_WEIGHT, $urandom_range(WSTORE_DEPTH, IDX_TOP), $urandom(), 1'b0);
      else
        queue_word(MODE_COORD, $urandom_range(MAX_INPUTS, IDX_TOP), $urandom(), 1'b0);
    end
    pick = $urandom_range(99);
    if (pick < 60)
      queue_word(MODE_COORD, (ni > 0) ? $urandom_range(ni - 1) : $urandom_range(MAX_INPUTS - 1),
                 rand_q16(), 1'b1);
    else if (pick < 85)
      queue_word(MODE_WEIGHT, (used > 0) ? $urandom_range(used - 1)
                                          : $urandom_range(WSTORE_DEPTH - 1), rand_q16(), 1'b1);
    else if (pick < 93)
      queue_word(MODE_WEIGHT, $urandom_range(WSTORE_DEPTH, IDX_TOP), $urandom(), 1'b1);
    else
      queue_word(MODE_COORD, $urandom_range(MAX_INPUTS, IDX_TOP), $urandom(), 1'b1);
  endtask

  task automatic wait_idle();
    while (words_to_send.size() != 0 || word_on_bus || evals_due.size() != 0)
      @(posedge clk);
  endtask

  // Write both registers once the block has gone quiet. The bits of cfg_data above
  // input_count are junk on purpose; the register keeps only its own width.
  task automatic set_config(int ic, int nc);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INPUT_COUNT;
    cfg_data <= CFG_DATA_W'(ic) | (CFG_DATA_W'($urandom_range(3)) << INCNT_W);
    @(negedge clk);
    cfg_index <= CFG_NODE_COUNT;
    cfg_data <= CFG_DATA_W'(nc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: present one word at a time, change only at the falling edge, and
  // insert a random gap after each accepted word.
  always @(negedge clk) begin : drive_words
    in_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!word_on_bus) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        w = words_to_send.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.mode <= w.mode;
        in_ch.index <= w.index;
        in_ch.value <= w.value;
        in_ch.last <= w.last;
        word_on_bus = 1'b1;
        send_gap = idle_len(send_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request so the
  // block fills up and has to push back on its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      take_gap = idle_len(take_calm);
    end
  end

  // Monitor: check results against the oldest prediction first, then mirror
  // register writes and accepted input words.
  always @(posedge clk) begin : watch_ports
    eval_result_t exp_r;
    if (!rst_n) begin
      input_count_q = INCNT_W'(16);
      node_count_q = NODECNT_W'(1);
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (evals_due.size() == 0) begin
          $error("result word with nothing expected: network_out %0d", out_ch.network_out);
          mismatch_count++;
        end else begin
          exp_r = evals_due.pop_front();
          if (out_ch.network_out !== exp_r.net) begin
            $error("network_out: expected %0d, got %0d", exp_r.net, out_ch.network_out);
            mismatch_count++;
          end
          if (out_ch.active_nodes !== exp_r.active) begin
            $error("active_nodes: expected %0d, got %0d", exp_r.active, out_ch.active_nodes);
            mismatch_count++;
          end
          if (out_ch.saturated_nodes !== exp_r.sat) begin
            $error("saturated_nodes: expected %0d, got %0d", exp_r.sat, out_ch.saturated_nodes);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INPUT_COUNT: input_count_q = cfg_data[INCNT_W-1:0];
          CFG_NODE_COUNT:  node_count_q = cfg_data[NODECNT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        // Apply the write first: a last word evaluates with its own value in place.
        if (in_ch.mode == MODE_WEIGHT && in_ch.index < WSTORE_DEPTH)
          wt_mirror[in_ch.index] = in_ch.value;
        else if (in_ch.mode == MODE_COORD && in_ch.index < MAX_INPUTS)
          crd_mirror[in_ch.index[XIDX_W-1:0]] = in_ch.value;
        if (in_ch.last) evals_due.push_back(eval_network());
        word_on_bus = 1'b0;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sigmoid_mlp_forward_eval_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int p, ni, nn;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_INPUT_COUNT;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: one input, two nodes. Node 0 passes the coordinate
    // straight through (in weight 1.0, bias 0) so each coordinate lands on a
    // chosen point of the sigmoid; node 1 starts with a zero out weight.
    set_config(1, 2);
    queue_word(MODE_WEIGHT, 0, 32'h0001_0000, 1'b0);
    queue_word(MODE_WEIGHT, 1, 32'h0001_0000, 1'b0);
    queue_word(MODE_WEIGHT, 2, 32'h0000_0000, 1'b0);
    queue_word(MODE_WEIGHT, 3, 32'h0000_0000, 1'b0);
    queue_word(MODE_WEIGHT, 4, 32'h7FFF_FFFF, 1'b0);
    queue_word(MODE_WEIGHT, 5, 32'h8000_0000, 1'b0);
    // Zero, each segment and its lower edge, the 10.0 threshold both ways, extremes.
    queue_word(MODE_COORD, 0, 32'h0000_0000, 1'b1);
    queue_word(MODE_COORD, 0, 32'h0000_8000, 1'b1);
    queue_word(MODE_COORD, 0, 32'h0001_0000, 1'b1);
    queue_word(MODE_COORD, 0, 32'h0002_0000, 1'b1);
    queue_word(MODE_COORD, 0, 32'h0002_6000, 1'b1);
    queue_word(MODE_COORD, 0, 32'h0004_0000, 1'b1);
    queue_word(MODE_COORD, 0, 32'h0005_0000, 1'b1);
    queue_word(MODE_COORD, 0, 32'h000A_0000, 1'b1);
    queue_word(MODE_COORD, 0, 32'hFFF6_0000, 1'b1);
    queue_word(MODE_COORD, 0, 32'h7FFF_FFFF, 1'b1);
    queue_word(MODE_COORD, 0, 32'h8000_0000, 1'b1);
    queue_word(MODE_COORD, 0, 32'hFFFF_FFFF, 1'b1);
    // Last on a weight write: wake node 1 with the most negative out weight.
    queue_word(MODE_WEIGHT, 3, 32'h8000_0000, 1'b1);
    // Out-of-range writes are dropped but still start an evaluation.
    queue_word(MODE_WEIGHT, IDX_TOP, 32'hFFFF_FFFF, 1'b1);
    queue_word(MODE_COORD, IDX_TOP, 32'h1234_5678, 1'b1);
    // Top word of the weight store: written, not read by this layout.
    queue_word(MODE_WEIGHT, WSTORE_DEPTH - 1, 32'h5555_AAAA, 1'b1);

    // Random part, phase by phase.
    for (p = 0; p < NUM_PHASES; p++) begin
      set_config(ph_inputs[p], ph_nodes[p]);
      ni = (ph_inputs[p] > MAX_INPUTS) ? MAX_INPUTS : ph_inputs[p];
      nn = (ph_nodes[p] > MAX_NODES) ? MAX_NODES : ph_nodes[p];
      load_used(ni, nn);
      if (p == PRESSURE_PHASE) hold_asks++;
      repeat (ph_evals[p]) random_eval(ni, nn);
    end

    // Drain, then give a stray result time to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && evals_due.size() == 0) begin
      $display("sigmoid_mlp_forward_eval_tb: done, clean");
    end else begin
      $display("sigmoid_mlp_forward_eval_tb: done, errors");
    end
    $finish;
  end

endmodule
